// ----- rtl/core/binary_morphology_3x3_assert.svh -----
// ----------------------------------------------------------------------------
// binary morphology assertion macros
// shared assertion forms, clocked on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef BINARY_MORPHOLOGY_3X3_ASSERT_SVH
`define BINARY_MORPHOLOGY_3X3_ASSERT_SVH

// same-cycle implication
`define BMORPH_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BMORPH_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/bmorph_pkg.sv -----
// ----------------------------------------------------------------------------
// bmorph_pkg
// types, register indexes and constants of the 3x3 binary morphology block
// ----------------------------------------------------------------------------
package bmorph_pkg;

   localparam int unsigned MAX_WIDTH_DEFAULT = 1024;
   localparam int unsigned HEIGHT_MAX        = 1024;

   localparam int unsigned CSR_DATA_W  = 11;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned ROW_W       = 11;
   localparam int unsigned OUT_ROW_W   = 10;
   localparam int unsigned WIN_W       = 9;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   localparam csr_index_type CSR_FRAME_WIDTH  = 2'd0;
   localparam csr_index_type CSR_FRAME_HEIGHT = 2'd1;
   localparam csr_index_type CSR_ERODE_MODE   = 2'd2;

   localparam csr_data_type FRAME_WIDTH_RESET  = 11'd450;
   localparam csr_data_type FRAME_HEIGHT_RESET = 11'd500;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic [7:0] PIX_MAX = 8'hFF;
   localparam logic [7:0] PIX_MIN = 8'h00;

   // window bit groups: bits 6..8 left column, 0..2 right column, bit 0 of a column is top
   localparam logic [WIN_W-1:0] MASK_LEFT   = 9'h1C0;
   localparam logic [WIN_W-1:0] MASK_RIGHT  = 9'h007;
   localparam logic [WIN_W-1:0] MASK_TOP    = 9'h049;
   localparam logic [WIN_W-1:0] MASK_BOTTOM = 9'h124;

   typedef struct packed {
      logic       op;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic white;
      logic frame_end;
   } rsp_type;

   // decisions made when an item is taken, carried to the window stage
   typedef struct packed {
      logic             mark;
      logic [WIN_W-1:0] mask;
      logic             emit;
      logic             last;
      logic             erode;
   } stage_type;

endpackage

// ----- rtl/core/bmorph_scan.sv -----
// ----------------------------------------------------------------------------
// bmorph_scan
// configuration registers, input and output raster counters, per item decisions
// ----------------------------------------------------------------------------
module bmorph_scan #(
   parameter int unsigned MAX_WIDTH = bmorph_pkg::MAX_WIDTH_DEFAULT,
   localparam int unsigned COL_W = $clog2(MAX_WIDTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  bmorph_pkg::csr_index_type  csr_index,
   input  bmorph_pkg::csr_data_type   csr_data,
   input  logic                       take,
   input  bmorph_pkg::req_type        req_data,
   output logic                       step,
   output bmorph_pkg::stage_type      stage,
   output logic [COL_W-1:0]           col
);
   import bmorph_pkg::*;

   localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);
   localparam int unsigned CMP_W = ((WID_W > CSR_DATA_W) ? WID_W : CSR_DATA_W) + 1;

   csr_data_type          frame_width_ff;
   csr_data_type          frame_height_ff;
   logic                  erode_mode_ff;

   logic [COL_W-1:0]      in_column_ff, in_column_in;
   logic [ROW_W-1:0]      in_row_ff, in_row_in;
   logic [COL_W-1:0]      out_column_ff, out_column_in;
   logic [OUT_ROW_W-1:0]  out_row_ff, out_row_in;

   logic [CMP_W-1:0]      width_ext;
   logic [CMP_W-1:0]      eff_width;
   logic [ROW_W-1:0]      eff_height;
   logic                  in_col_wrap;
   logic                  out_col_last;
   logic                  out_row_last;
   logic                  flush;
   logic                  filling;
   logic                  pix_white;
   logic                  pix_black;
   logic                  emit;
   logic                  last;
   logic [WIN_W-1:0]      mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         erode_mode_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            CSR_ERODE_MODE:   erode_mode_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // clamp width to the row buffer, height to HEIGHT_MAX; a zero size is one
   always_comb begin
      width_ext = CMP_W'(frame_width_ff);
      if (width_ext == '0) begin
         eff_width = CMP_W'(1);
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         eff_width = CMP_W'(MAX_WIDTH);
      end else begin
         eff_width = width_ext;
      end
      if (frame_height_ff == '0) begin
         eff_height = ROW_W'(1);
      end else if (frame_height_ff > ROW_W'(HEIGHT_MAX)) begin
         eff_height = ROW_W'(HEIGHT_MAX);
      end else begin
         eff_height = frame_height_ff;
      end
   end

   assign in_col_wrap  = (CMP_W'(in_column_ff) + CMP_W'(1)) >= eff_width;
   assign out_col_last = (CMP_W'(out_column_ff) + CMP_W'(1)) >= eff_width;
   assign out_row_last = (ROW_W'(out_row_ff) + ROW_W'(1)) >= eff_height;

   assign flush     = (req_data.op == OP_FLUSH);
   assign filling   = (in_row_ff < eff_height);
   assign pix_white = (req_data.red == PIX_MAX) && (req_data.green == PIX_MAX) &&
                      (req_data.blue == PIX_MAX);
   assign pix_black = (req_data.red == PIX_MIN) && (req_data.green == PIX_MIN) &&
                      (req_data.blue == PIX_MIN);

   // output trails the input by one row plus one pixel
   assign emit = (in_row_ff >= ROW_W'(2)) ||
                 ((in_row_ff == ROW_W'(1)) && (in_column_ff != '0));
   assign last = emit && out_col_last && out_row_last;

   always_comb begin
      mask = '1;
      if (out_column_ff == '0) begin
         mask = mask & ~MASK_LEFT;
      end
      if (out_col_last) begin
         mask = mask & ~MASK_RIGHT;
      end
      if (out_row_ff == '0) begin
         mask = mask & ~MASK_TOP;
      end
      if (out_row_last) begin
         mask = mask & ~MASK_BOTTOM;
      end
   end

   // a flush before the frame's last pixel is dropped without effect
   assign step = take && !(flush && filling);

   always_comb begin
      stage.mark  = !flush && filling && (erode_mode_ff ? pix_black : pix_white);
      stage.mask  = mask;
      stage.emit  = emit;
      stage.last  = last;
      stage.erode = erode_mode_ff;
   end

   assign col = in_column_ff;

   always_comb begin
      in_column_in  = in_column_ff;
      in_row_in     = in_row_ff;
      out_column_in = out_column_ff;
      out_row_in    = out_row_ff;
      if (step) begin
         if (last) begin
            in_column_in  = '0;
            in_row_in     = '0;
            out_column_in = '0;
            out_row_in    = '0;
         end else begin
            if (emit) begin
               if (out_col_last) begin
                  out_column_in = '0;
                  out_row_in    = out_row_ff + OUT_ROW_W'(1);
               end else begin
                  out_column_in = out_column_ff + COL_W'(1);
               end
            end
            if (in_col_wrap) begin
               in_column_in = '0;
               in_row_in    = in_row_ff + ROW_W'(1);
            end else begin
               in_column_in = in_column_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff  <= '0;
         in_row_ff     <= '0;
         out_column_ff <= '0;
         out_row_ff    <= '0;
      end else begin
         in_column_ff  <= in_column_in;
         in_row_ff     <= in_row_in;
         out_column_ff <= out_column_in;
         out_row_ff    <= out_row_in;
      end
   end

endmodule

// ----- rtl/core/bmorph_linebuf.sv -----
// ----------------------------------------------------------------------------
// bmorph_linebuf
// two-row mark memory, one read and one write per cycle, with write forwarding
// ----------------------------------------------------------------------------
module bmorph_linebuf #(
   parameter int unsigned MAX_WIDTH = bmorph_pkg::MAX_WIDTH_DEFAULT,
   localparam int unsigned COL_W = $clog2(MAX_WIDTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  logic [1:0]       wr_data,
   output logic [1:0]       rd_marks
);
   import bmorph_pkg::*;

   // bit 0 newer row, bit 1 older row
   logic [1:0] mem [MAX_WIDTH];
   logic [1:0] rd_data_ff;
   logic       fwd_valid_ff;
   logic [1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // a read issued at the edge that writes the same column sees the new value
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_valid_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_marks = fwd_valid_ff ? fwd_data_ff : rd_data_ff;

endmodule

// ----- rtl/core/bmorph_window.sv -----
// ----------------------------------------------------------------------------
// bmorph_window
// window stage: 3x3 mark window, row mark update and result register
// ----------------------------------------------------------------------------
`include "binary_morphology_3x3_assert.svh"

module bmorph_window #(
   parameter int unsigned MAX_WIDTH = bmorph_pkg::MAX_WIDTH_DEFAULT,
   localparam int unsigned COL_W = $clog2(MAX_WIDTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  bmorph_pkg::stage_type  stage,
   input  logic [COL_W-1:0]       col,
   input  logic [1:0]             rd_marks,
   output logic                   wr_en,
   output logic [COL_W-1:0]       wr_addr,
   output logic [1:0]             wr_data,
   output logic                   busy,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output bmorph_pkg::rsp_type    rsp_data
);
   import bmorph_pkg::*;

   logic             b_valid_ff, b_valid_in;
   stage_type        b_stage_ff;
   logic [COL_W-1:0] b_col_ff;
   logic [WIN_W-1:0] window_ff, window_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;

   logic [2:0]       new_col;
   logic [WIN_W-1:0] win_next;
   logic             any_mark;
   logic             b_go;

   // new right column: top is the older row, bottom is the incoming mark
   assign new_col  = {b_stage_ff.mark, rd_marks[0], rd_marks[1]};
   assign win_next = {window_ff[WIN_W-4:0], new_col};
   assign any_mark = |(win_next & b_stage_ff.mask);

   assign b_go = b_valid_ff && (!b_stage_ff.emit || !rsp_valid_ff || !rsp_stall);
   assign busy = b_valid_ff && !b_go;

   assign wr_en   = b_go;
   assign wr_addr = b_col_ff;
   assign wr_data = {rd_marks[0], b_stage_ff.mark};

   always_comb begin
      b_valid_in = b_valid_ff;
      if (step) begin
         b_valid_in = 1'b1;
      end else if (b_go) begin
         b_valid_in = 1'b0;
      end
      window_in = window_ff;
      if (b_go) begin
         window_in = b_stage_ff.last ? '0 : win_next;
      end
      rsp_valid_in = rsp_valid_ff;
      if (b_go && b_stage_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         window_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         b_stage_ff <= stage;
         b_col_ff   <= col;
      end
      if (b_go && b_stage_ff.emit) begin
         rsp_data_ff.white     <= b_stage_ff.erode ? !any_mark : any_mark;
         rsp_data_ff.frame_end <= b_stage_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `BMORPH_ASSERT_IMP(a_step_into_free_stage, step, (!b_valid_ff || b_go), "item entered a held window stage")
   `BMORPH_ASSERT_NXT(a_window_cleared, (b_go && b_stage_ff.last), (window_ff == '0), "window not cleared after frame end")
   `BMORPH_ASSERT_NXT(a_result_loaded, (b_go && b_stage_ff.emit), (rsp_valid_ff && (rsp_data_ff.frame_end == $past(b_stage_ff.last))), "emitting item left no result")

endmodule

// ----- rtl/core/binary_morphology_3x3.sv -----
// ----------------------------------------------------------------------------
// binary_morphology_3x3
// 3x3 binary dilation / erosion on a raster rgb pixel stream
// ----------------------------------------------------------------------------
//
//   channel | ports                          | carries
//   --------+--------------------------------+---------------------------------
//   request | req_valid req_stall req_data   | op, red, green, blue
//   result  | rsp_valid rsp_stall rsp_data   | white, frame_end
//   csr     | csr_we csr_index csr_data      | frame_width, frame_height, erode
//
// one item per cycle sustained while req_stall is low; a taken item and the
// registered read of the row mark memory (one read and one write port, used
// once per item) feed the window stage, whose result is then registered.
// synchronous reset clears counters, window and valid flags; the row mark
// memory is not cleared, entries of the row above the frame are masked out.
// req_stall rises only while a result waits under rsp_stall and the item in
// the window stage has a result of its own to give.
// ----------------------------------------------------------------------------
module binary_morphology_3x3 #(
   parameter int unsigned MAX_WIDTH = bmorph_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  bmorph_pkg::csr_index_type  csr_index,
   input  bmorph_pkg::csr_data_type   csr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  bmorph_pkg::req_type        req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output bmorph_pkg::rsp_type        rsp_data
);
   import bmorph_pkg::*;

   localparam int unsigned COL_W = $clog2(MAX_WIDTH);

   logic             take;
   logic             step;
   stage_type        stage;
   logic [COL_W-1:0] col;
   logic [1:0]       rd_marks;
   logic             wr_en;
   logic [COL_W-1:0] wr_addr;
   logic [1:0]       wr_data;
   logic             busy;

   assign take      = req_valid && !req_stall;
   assign req_stall = busy;

   bmorph_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .take      (take),
      .req_data  (req_data),
      .step      (step),
      .stage     (stage),
      .col       (col)
   );

   bmorph_linebuf #(.MAX_WIDTH(MAX_WIDTH)) u_linebuf (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (step),
      .rd_addr  (col),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_marks (rd_marks)
   );

   bmorph_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .stage     (stage),
      .col       (col),
      .rd_marks  (rd_marks),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .busy      (busy),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
